[sv/scge_pkg.sv]
package scge_pkg;
  localparam int unsigned NItems = 64;
  localparam int unsigned IdxW = 6;
  localparam int unsigned KAddrW = 12;
  localparam int unsigned SumW = 22;
  localparam int unsigned AlphaW = 17;
  localparam int unsigned ResW = 40;

  localparam logic [2:0] ReqWrite = 3'd0;
  localparam logic [2:0] ReqClear = 3'd1;
  localparam logic [2:0] ReqAdd = 3'd2;
  localparam logic [2:0] ReqRemove = 3'd3;
  localparam logic [2:0] ReqAddGain = 3'd4;
  localparam logic [2:0] ReqRemGain = 3'd5;
  localparam logic [2:0] ReqEval = 3'd6;

  typedef struct packed {
    logic           start;
    logic [2:0]     op;
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] row;
    logic [15:0]    val;
  } scge_cmd_t;

  typedef struct packed {
    logic           done;
    logic           busy;
    logic [ResW-1:0] result;
    logic           status;
  } scge_sts_t;
endpackage

[sv/scge_ram.sv]
module scge_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[sv/scge_datapath.sv]
module scge_datapath import scge_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [AlphaW-1:0] alpha_i,
  input  scge_cmd_t       cmd_i,
  output scge_sts_t       sts_o
);
  // phases: clear sweep, walk (issue reads, then combine in the next cycle)
  logic            busy_q, busy_d;
  logic            clr_q, clr_d;
  logic [KAddrW-1:0] swp_q, swp_d;
  logic [2:0]      op_q;
  logic [IdxW-1:0] col_q, row_q;
  logic [15:0]     val_q;
  logic [IdxW:0]   cnt_q, cnt_d;
  logic            pv_q;
  logic [IdxW-1:0] pi_q;
  logic [ResW-1:0] acc_q, acc_d;
  logic            st_q, st_d;
  logic            done_q;
  logic [NItems-1:0] mem_q;
  logic [NItems-1:0] cvld_q;  // coverage entry valid (cleared by clear stats)

  logic k_we, r_we, c_we;
  logic [KAddrW-1:0] k_wa, k_ra;
  logic [15:0] k_wd, k_rd;
  logic [IdxW-1:0] r_wa, r_ra, c_wa, c_ra;
  logic [SumW-1:0] r_wd, r_rd, c_wd, c_rd;
  logic [SumW-1:0] r_v, c_v;
  logic [15:0] k_v;
  logic [IdxW-1:0] ra;
  logic [IdxW:0] ra_full;

  scge_ram #(.Width(16), .Depth(NItems*NItems)) u_k (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(k_wd), .raddr_i(k_ra), .rdata_o(k_rd));
  scge_ram #(.Width(SumW), .Depth(NItems)) u_r (
    .clk_i, .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd), .raddr_i(r_ra), .rdata_o(r_rd));
  scge_ram #(.Width(SumW), .Depth(NItems)) u_c (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c_ra), .rdata_o(c_rd));

  logic vc_q;
  assign k_v = k_rd;
  assign r_v = r_rd;
  assign c_v = vc_q ? c_rd : '0;

  logic is_wr;
  assign is_wr = (op_q == ReqWrite);
  assign ra_full = cnt_q;
  assign ra = is_wr ? row_q : ra_full[IdxW-1:0];
  assign k_ra = is_wr ? {row_q, col_q} : {ra, col_q};
  assign r_ra = ra;
  assign c_ra = ra;

  logic issue;
  assign issue = busy_q && !clr_q && (is_wr ? (cnt_q == 0) : !cnt_q[IdxW]);

  logic [AlphaW+SumW-1:0] prod;
  logic [SumW:0] thr, cp, cm, a1, a0;
  assign prod = alpha_i * r_v;
  assign thr = (prod >> 16) > {{(AlphaW-1){1'b0}}, 1'b1, {SumW{1'b0}}} ?
               {1'b1, {SumW{1'b0}}} : (SumW+1)'(prod >> 16);
  assign cp = {1'b0, c_v} + {7'd0, k_v};
  assign cm = (c_v >= {6'd0, k_v}) ? {1'b0, c_v - {6'd0, k_v}} : '0;

  always_comb begin
    a1 = '0;
    a0 = '0;
    case (op_q)
      ReqAddGain: begin
        a1 = (cp < thr) ? cp : thr;
        a0 = ({1'b0, c_v} < thr) ? {1'b0, c_v} : thr;
      end
      ReqRemGain: begin
        a1 = ({1'b0, c_v} < thr) ? {1'b0, c_v} : thr;
        a0 = (cm < thr) ? cm : thr;
      end
      ReqEval: a1 = ({1'b0, c_v} < thr) ? {1'b0, c_v} : thr;
      default: ;
    endcase
  end

  logic [SumW-1:0] rs_new, cv_new;
  assign rs_new = r_v - {6'd0, k_v} + {6'd0, val_q};
  assign cv_new = c_v - {6'd0, k_v} + {6'd0, val_q};

  always_comb begin
    busy_d = busy_q;
    clr_d = clr_q;
    swp_d = swp_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    st_d = st_q;
    k_we = 1'b0; k_wa = {row_q, col_q}; k_wd = val_q;
    r_we = 1'b0; r_wa = pi_q; r_wd = rs_new;
    c_we = 1'b0; c_wa = pi_q; c_wd = '0;
    if (clr_q) begin
      k_we = 1'b1;
      k_wa = swp_q;
      k_wd = '0;
      r_we = (swp_q[KAddrW-1:IdxW] == '0);
      r_wa = swp_q[IdxW-1:0];
      r_wd = '0;
      swp_d = swp_q + 1'b1;
      if (&swp_q) clr_d = 1'b0;
    end
    if (issue) cnt_d = cnt_q + 1'b1;
    if (pv_q) begin
      case (op_q)
        ReqWrite: begin
          k_we = 1'b1;
          r_we = 1'b1;
          if (mem_q[col_q]) begin
            c_we = 1'b1;
            c_wd = cv_new;
          end
        end
        ReqAdd: begin
          c_we = 1'b1;
          c_wd = cp[SumW-1:0];
        end
        ReqRemove: begin
          c_we = 1'b1;
          c_wd = cm[SumW-1:0];
        end
        default: acc_d = acc_q + ResW'(a1 - a0);
      endcase
    end
    if (busy_q && !clr_q && !issue && !pv_q) busy_d = 1'b0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d = '0;
      acc_d = '0;
      st_d = 1'b0;
      case (cmd_i.op)
        ReqClear: busy_d = 1'b0;
        ReqAdd, ReqAddGain: if (mem_q[cmd_i.col]) begin
          st_d = 1'b1;
          busy_d = 1'b0;
        end
        ReqRemove, ReqRemGain: if (!mem_q[cmd_i.col]) begin
          st_d = 1'b1;
          busy_d = 1'b0;
        end
        ReqWrite, ReqEval: ;
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; clr_q <= 1'b1; swp_q <= '0; cnt_q <= '0; pv_q <= 1'b0; pi_q <= '0;
      acc_q <= '0; st_q <= 1'b0; done_q <= 1'b0; mem_q <= '0;
      cvld_q <= '0; op_q <= ReqEval; col_q <= '0; row_q <= '0; val_q <= '0;
      vc_q <= 1'b0;
    end else begin
      busy_q <= busy_d; clr_q <= clr_d; swp_q <= swp_d; cnt_q <= cnt_d; acc_q <= acc_d;
      st_q <= st_d;
      pv_q <= issue;
      pi_q <= ra;
      vc_q <= cvld_q[ra];
      if (c_we) cvld_q[c_wa] <= 1'b1;
      done_q <= cmd_i.start ? !busy_d : (busy_q && !busy_d);
      if (busy_q && !busy_d) begin
        if (op_q == ReqAdd) mem_q[col_q] <= 1'b1;
        if (op_q == ReqRemove) mem_q[col_q] <= 1'b0;
      end
      if (cmd_i.start) begin
        op_q <= cmd_i.op; col_q <= cmd_i.col; row_q <= cmd_i.row; val_q <= cmd_i.val;
        if (cmd_i.op == ReqClear) begin
          mem_q <= '0;
          cvld_q <= '0;
        end
      end
    end
  end

  // zero kernel and row sums in one clearing pass after reset
  assign sts_o.done = done_q;
  assign sts_o.busy = busy_q | clr_q;
  assign sts_o.result = acc_q;
  assign sts_o.status = st_q;
endmodule

[sv/scge_ctrl.sv]
module scge_ctrl import scge_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      req_type_i,
  input  logic [IdxW-1:0] element_index_i,
  input  logic [IdxW-1:0] kernel_row_i,
  input  logic [15:0]     kernel_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ResW-1:0] result_value_o,
  output logic            status_o,
  output scge_cmd_t       cmd_o,
  input  scge_sts_t       sts_i
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun = 2'd1;
  localparam logic [1:0] StOut = 2'd2;

  logic [1:0] state_q, state_d;
  logic [ResW-1:0] res_q;
  logic st_q;
  logic acc;

  assign in_ready_o = (state_q == StIdle) && !sts_i.busy;
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign result_value_o = res_q;
  assign status_o = st_q;

  assign cmd_o.start = acc;
  assign cmd_o.op = req_type_i;
  assign cmd_o.col = element_index_i;
  assign cmd_o.row = kernel_row_i;
  assign cmd_o.val = kernel_value_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (acc) state_d = StRun;
      StRun: if (sts_i.done) state_d = StOut;
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      res_q <= '0;
      st_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StRun && sts_i.done) begin
        res_q <= sts_i.result;
        st_q <= sts_i.status;
      end
    end
  end
endmodule

[sv/saturated_coverage_gain_engine_unit.sv]
// Kernel writes read and rewrite a single entry; clears, refused and unused requests
// finish without a walk; add, remove, gain and evaluate take one serial walk over all rows.
// Throughput: one item at a time; next item accepted the edge after the result is taken.
// Reset (rst_ni low, async): alpha 1.0, set empty; a clearing pass over all kernel
// entries then zeroes kernel and row sums, and no item is accepted until it ends.
module saturated_coverage_gain_engine_unit import scge_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [AlphaW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      req_type_i,
  input  logic [IdxW-1:0] element_index_i,
  input  logic [IdxW-1:0] kernel_row_i,
  input  logic [15:0]     kernel_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ResW-1:0] result_value_o,
  output logic            status_o
);
  logic [AlphaW-1:0] alpha_q;
  scge_cmd_t cmd;
  scge_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaW'(65536);
    end else if (cfg_we_i) begin
      alpha_q <= cfg_wdata_i;
    end
  end

  scge_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .element_index_i,
    .kernel_row_i, .kernel_value_i, .out_valid_o, .out_ready_i, .result_value_o,
    .status_o, .cmd_o(cmd), .sts_i(sts));

  scge_datapath u_dp (
    .clk_i, .rst_ni, .alpha_i(alpha_q), .cmd_i(cmd), .sts_o(sts));
endmodule
